// File: src/pwl_lut_pkg.sv
package pwl_lut_pkg;

    localparam int NUM_POINTS = 31;
    localparam int LAST       = NUM_POINTS - 1;
    localparam int NUM_SEGS   = NUM_POINTS - 1;
    localparam int IDX_W      = $clog2(NUM_POINTS);

    localparam int REF_W   = 16;
    localparam int VOLT_W  = 16;
    localparam int MV_W    = 12;
    localparam int SLOPE_W = 7;
    localparam int FRAC_W  = 10;
    localparam int HALF_W  = 9;
    localparam int RECIP_W = 25;
    localparam int NUM_W   = FRAC_W + SLOPE_W + 4;
    localparam int SHIFT   = 32;
    localparam int QUO_W   = 11;

    localparam logic AXIS_LINEAR  = 1'b0;
    localparam logic AXIS_ANGULAR = 1'b1;

    typedef logic signed [REF_W-1:0] ref_t;
    typedef logic [MV_W-1:0]         mv_t;

    localparam ref_t BRK [0:NUM_POINTS-1] = '{
        -16'sd10000, -16'sd9000, -16'sd8000, -16'sd7000, -16'sd6000, -16'sd5000,
        -16'sd4000,  -16'sd3000, -16'sd2000, -16'sd1500, -16'sd1000, -16'sd800,
        -16'sd600,   -16'sd400,  -16'sd200,  16'sd0,
        16'sd200,    16'sd400,   16'sd600,   16'sd800,   16'sd1000,  16'sd1500,
        16'sd2000,   16'sd3000,  16'sd4000,  16'sd5000,  16'sd6000,  16'sd7000,
        16'sd8000,   16'sd9000,  16'sd10000
    };

    localparam mv_t LIN_MV [0:NUM_POINTS-1] = '{
        12'd1789, 12'd1868, 12'd1947, 12'd2027, 12'd2106, 12'd2185, 12'd2264, 12'd2343,
        12'd2423, 12'd2462, 12'd2502, 12'd2518, 12'd2533, 12'd2549, 12'd2565,
        12'd2689,
        12'd2813, 12'd2829, 12'd2845, 12'd2860, 12'd2876, 12'd2916, 12'd2955, 12'd3035,
        12'd3114, 12'd3193, 12'd3272, 12'd3351, 12'd3431, 12'd3510, 12'd3589
    };

    localparam mv_t ANG_MV [0:NUM_POINTS-1] = '{
        12'd2005, 12'd2067, 12'd2128, 12'd2190, 12'd2252, 12'd2313, 12'd2375, 12'd2436,
        12'd2498, 12'd2529, 12'd2559, 12'd2572, 12'd2584, 12'd2596, 12'd2609,
        12'd2705,
        12'd2801, 12'd2814, 12'd2826, 12'd2838, 12'd2851, 12'd2882, 12'd2912, 12'd2974,
        12'd3036, 12'd3097, 12'd3159, 12'd3220, 12'd3282, 12'd3344, 12'd3405
    };

    localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd4294968;
    localparam logic [RECIP_W-1:0] RECIP_500  = 25'd8589935;
    localparam logic [RECIP_W-1:0] RECIP_200  = 25'd21474837;

    localparam logic [RECIP_W-1:0] SEG_RECIP [0:NUM_SEGS-1] = '{
        RECIP_1000, RECIP_1000, RECIP_1000, RECIP_1000,
        RECIP_1000, RECIP_1000, RECIP_1000, RECIP_1000,
        RECIP_500,  RECIP_500,
        RECIP_200,  RECIP_200,  RECIP_200,  RECIP_200,  RECIP_200,
        RECIP_200,  RECIP_200,  RECIP_200,  RECIP_200,  RECIP_200,
        RECIP_500,  RECIP_500,
        RECIP_1000, RECIP_1000, RECIP_1000, RECIP_1000, RECIP_1000,
        RECIP_1000, RECIP_1000, RECIP_1000
    };

    localparam logic [HALF_W-1:0] SEG_HALF [0:NUM_SEGS-1] = '{
        9'd500, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500,
        9'd250, 9'd250,
        9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100,
        9'd250, 9'd250,
        9'd500, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500
    };

endpackage

// File: src/dual_axis_piecewise_linear_lut_core.sv
// Two-axis piecewise-linear voltage lookup.
// Slave stream: s_tdata carries the signed reference (units of 0.0001),
// s_tuser the axis (0 linear-velocity table, 1 angular-velocity table).
// Master stream: m_tdata carries the drive voltage in 1/16 mV, m_tuser is
// set when the reference sat at or beyond either end of the table.
// Every beat in gives exactly one beat out, in order, after the stages
// segment search, table ROM read, fraction times slope, multiply
// by the reciprocal of the segment width, final add into the output register.
// The five-stage pipeline takes one beat per cycle while the output flows.
// A stall on m_tready freezes every stage at once; s_tready drops for as long
// as a result waits in the output register and the receiver holds off.
// Reset (aresetn low, synchronous) empties the pipeline; no result is lost
// or repeated across a stall. The tables are fixed; nothing needs loading.
module dual_axis_piecewise_linear_lut_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reference
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // drive_voltage
    output logic        m_tuser    // clamped
);

    localparam int IW = pwl_lut_pkg::IDX_W;

    logic adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;

    logic                      op1_reg;
    pwl_lut_pkg::ref_t         x1_reg;
    logic [IW-1:0]             p1_reg;
    logic                      cl1_reg;

    pwl_lut_pkg::ref_t                    x2_reg;
    pwl_lut_pkg::ref_t                    lo2_reg;
    pwl_lut_pkg::mv_t                     base2_reg;
    logic [pwl_lut_pkg::SLOPE_W-1:0]      slope2_reg;
    logic [pwl_lut_pkg::HALF_W-1:0]       half2_reg;
    logic [pwl_lut_pkg::RECIP_W-1:0]      recip2_reg;
    logic                                 cl2_reg;

    logic [pwl_lut_pkg::NUM_W-1:0]        num3_reg;
    logic [pwl_lut_pkg::RECIP_W-1:0]      recip3_reg;
    pwl_lut_pkg::mv_t                     base3_reg;
    logic                                 cl3_reg;

    logic [pwl_lut_pkg::QUO_W-1:0]        q4_reg;
    pwl_lut_pkg::mv_t                     base4_reg;
    logic                                 cl4_reg;

    logic [pwl_lut_pkg::VOLT_W-1:0]       volt_reg;
    logic                                 clo_reg;

    pwl_lut_pkg::ref_t  x_in;
    logic               lo_in, hi_in;
    logic [IW-1:0]      cnt;
    logic [IW-1:0]      p_next;

    logic [IW-1:0]                        seg_idx;
    pwl_lut_pkg::mv_t                     mv_cur, mv_nxt;

    logic signed [pwl_lut_pkg::REF_W:0]   diff;
    logic [pwl_lut_pkg::FRAC_W-1:0]       frac;
    logic [pwl_lut_pkg::FRAC_W+pwl_lut_pkg::SLOPE_W-1:0] fs;
    logic [pwl_lut_pkg::NUM_W-1:0]        num_next;

    logic [pwl_lut_pkg::NUM_W+pwl_lut_pkg::RECIP_W-1:0] prod;

    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vo_reg;
    assign m_tdata  = volt_reg;
    assign m_tuser  = clo_reg;

    // segment search by parallel compares against the inner breakpoints
    always_comb begin
        x_in  = pwl_lut_pkg::ref_t'(s_tdata);
        lo_in = x_in <= pwl_lut_pkg::BRK[0];
        hi_in = x_in >= pwl_lut_pkg::BRK[pwl_lut_pkg::LAST];
        cnt   = '0;
        for (int j = 1; j < pwl_lut_pkg::LAST; j++) begin
            if (x_in > pwl_lut_pkg::BRK[j]) begin
                cnt = cnt + IW'(1);
            end
        end
        if (lo_in) begin
            p_next = '0;
        end else if (hi_in) begin
            p_next = IW'(pwl_lut_pkg::LAST);
        end else begin
            p_next = cnt;
        end
    end

    // table ROM read address
    always_comb begin
        mv_cur  = (op1_reg == pwl_lut_pkg::AXIS_ANGULAR) ?
                  pwl_lut_pkg::ANG_MV[p1_reg] : pwl_lut_pkg::LIN_MV[p1_reg];
        seg_idx = (p1_reg == IW'(pwl_lut_pkg::LAST)) ? '0 : p1_reg;
        mv_nxt  = (op1_reg == pwl_lut_pkg::AXIS_ANGULAR) ?
                  pwl_lut_pkg::ANG_MV[seg_idx + IW'(1)] :
                  pwl_lut_pkg::LIN_MV[seg_idx + IW'(1)];
    end

    always_comb begin
        diff     = (pwl_lut_pkg::REF_W+1)'(x2_reg) - (pwl_lut_pkg::REF_W+1)'(lo2_reg);
        frac     = cl2_reg ? '0 : diff[pwl_lut_pkg::FRAC_W-1:0];
        fs       = frac * slope2_reg;
        num_next = {fs, 4'b0000} + pwl_lut_pkg::NUM_W'(half2_reg);
        prod     = num3_reg * recip3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg    <= s_tuser;
            x1_reg     <= x_in;
            p1_reg     <= p_next;
            cl1_reg    <= lo_in || hi_in;

            x2_reg     <= x1_reg;
            lo2_reg    <= pwl_lut_pkg::BRK[p1_reg];
            base2_reg  <= mv_cur;
            slope2_reg <= cl1_reg ? '0 : pwl_lut_pkg::SLOPE_W'(mv_nxt - mv_cur);
            half2_reg  <= pwl_lut_pkg::SEG_HALF[seg_idx];
            recip2_reg <= pwl_lut_pkg::SEG_RECIP[seg_idx];
            cl2_reg    <= cl1_reg;

            num3_reg   <= num_next;
            recip3_reg <= recip2_reg;
            base3_reg  <= base2_reg;
            cl3_reg    <= cl2_reg;

            q4_reg     <= prod[pwl_lut_pkg::SHIFT+pwl_lut_pkg::QUO_W-1:pwl_lut_pkg::SHIFT];
            base4_reg  <= base3_reg;
            cl4_reg    <= cl3_reg;

            volt_reg   <= {base4_reg, 4'b0000} + pwl_lut_pkg::VOLT_W'(q4_reg);
            clo_reg    <= cl4_reg;
        end
    end

endmodule

// File: verif/drive_voltage_checker.sv
module drive_voltage_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // reference
    input  logic        s_tuser,   // operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // drive_voltage
    input  logic        m_tuser,   // clamped
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KNOT [0:30] = '{
        -10000, -9000, -8000, -7000, -6000, -5000, -4000, -3000,
        -2000, -1500, -1000, -800, -600, -400, -200,
        0,
        200, 400, 600, 800, 1000, 1500, 2000, 3000,
        4000, 5000, 6000, 7000, 8000, 9000, 10000
    };

    localparam int LIN_TAB [0:30] = '{
        1789, 1868, 1947, 2027, 2106, 2185, 2264, 2343,
        2423, 2462, 2502, 2518, 2533, 2549, 2565,
        2689,
        2813, 2829, 2845, 2860, 2876, 2916, 2955, 3035,
        3114, 3193, 3272, 3351, 3431, 3510, 3589
    };

    localparam int ANG_TAB [0:30] = '{
        2005, 2067, 2128, 2190, 2252, 2313, 2375, 2436,
        2498, 2529, 2559, 2572, 2584, 2596, 2609,
        2705,
        2801, 2814, 2826, 2838, 2851, 2882, 2912, 2974,
        3036, 3097, 3159, 3220, 3282, 3344, 3405
    };

    typedef struct packed {
        logic [15:0] volt;
        logic        clamped;
    } volt_beat_t;

    volt_beat_t volt_queue [$];

    function automatic longint table_mv(input logic axis, input int idx);
        return (axis == pwl_lut_pkg::AXIS_ANGULAR) ? ANG_TAB[idx] : LIN_TAB[idx];
    endfunction

    function automatic volt_beat_t predict_drive(input logic axis,
                                                 input logic signed [15:0] refv);
        volt_beat_t res;
        longint     x;
        longint     lo_mv;
        longint     span;
        longint     total;
        longint     q;
        int         seg;
        x           = refv;
        res.clamped = 1'b1;
        if (x <= KNOT[0]) begin
            q = 16 * table_mv(axis, 0);
        end else if (x >= KNOT[30]) begin
            q = 16 * table_mv(axis, 30);
        end else begin
            res.clamped = 1'b0;
            seg = 0;
            while (x > KNOT[seg+1])
                seg++;
            lo_mv = table_mv(axis, seg);
            span  = KNOT[seg+1] - KNOT[seg];
            total = 16 * (lo_mv * span + (x - KNOT[seg]) * (table_mv(axis, seg + 1) - lo_mv));
            q     = (2 * total + span) / (2 * span);
        end
        if (q < 0)
            res.volt = 16'h0000;
        else if (q > 65535)
            res.volt = 16'hFFFF;
        else
            res.volt = 16'(q);
        return res;
    endfunction

    always @(posedge aclk) begin
        volt_beat_t want;
        if (!aresetn) begin
            volt_queue.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (volt_queue.size() == 0) begin
                    $display("%0t: unexpected beat, got volt %0d clamped %0b",
                             $time, m_tdata, m_tuser);
                    mismatches <= mismatches + 1;
                end else begin
                    want = volt_queue.pop_front();
                    if (want.volt !== m_tdata || want.clamped !== m_tuser) begin
                        $display("%0t: mismatch, expected volt %0d clamped %0b, got volt %0d clamped %0b",
                                 $time, want.volt, want.clamped, m_tdata, m_tuser);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                volt_queue.push_back(predict_drive(s_tuser, s_tdata));
            outstanding <= volt_queue.size();
        end
    end

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BEATS  = 90;

    localparam logic signed [15:0] CORNER_REFS [0:11] = '{
        16'sh8000, 16'sh7FFF, -16'sd10000, 16'sd10000, -16'sd10001, 16'sd10001,
        -16'sd9999, 16'sd9999, 16'sd0, -16'sd200, 16'sd1500, 16'sd777
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tuser;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    dual_axis_piecewise_linear_lut_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    drive_voltage_checker volt_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_ref(input logic axis, input logic [15:0] refv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= refv;
        s_tuser  <= axis;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid and hold until the pipeline has emptied
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [15:0] pick_ref();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return 16'($urandom_range(0, 65535));
        else if (sel < 4)
            return 16'(pwl_lut_pkg::BRK[$urandom_range(0, pwl_lut_pkg::NUM_POINTS - 1)]
                       + $urandom_range(0, 2) - 1);
        else
            return 16'($urandom_range(0, 20000) - 10000);
    endfunction

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASE_BEATS)
            send_ref(1'($urandom_range(0, 1)), pick_ref());
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int axis = 0; axis < 2; axis++)
            foreach (CORNER_REFS[k])
                send_ref(1'(axis), CORNER_REFS[k]);
        drain_results();

        run_phase(0, 0);
        run_phase(56, 0);
        run_phase(0, 56);
        run_phase(18, 18);
        run_phase(0, 0);

        recv_idle_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
